[sv/jse_pkg.sv]
`default_nettype none
package jse_pkg;

    // Held-byte store: two banks of four entries, addressed {bank, index}.
    localparam int RamWidth = 8;
    localparam int RamDepth = 8;
    localparam int RamAw    = $clog2(RamDepth);

    // Body kinds of one output job.
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_CLOSE = 3'd1;
    localparam logic [2:0] K_RAW   = 3'd2;
    localparam logic [2:0] K_ESC2  = 3'd3;
    localparam logic [2:0] K_U1    = 3'd4;
    localparam logic [2:0] K_U2    = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_U     = 8'h75;

    // One input item's worth of output: optional opening quote, held bytes
    // replayed from the store, then a body.
    typedef struct packed {
        logic        open;
        logic [1:0]  nheld;
        logic        bank;
        logic [2:0]  kind;
        logic [7:0]  c;
        logic [15:0] v0;
        logic [15:0] v1;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

    function automatic logic [3:0] body_len(input logic [2:0] kind);
        case (kind)
            K_CLOSE: return 4'd1;
            K_RAW:   return 4'd1;
            K_ESC2:  return 4'd2;
            K_U1:    return 4'd6;
            K_U2:    return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] u_byte(input logic [15:0] v, input logic [2:0] k);
        case (k)
            3'd0:    return CH_BSL;
            3'd1:    return CH_U;
            3'd2:    return hex_char(v[15:12]);
            3'd3:    return hex_char(v[11:8]);
            3'd4:    return hex_char(v[7:4]);
            default: return hex_char(v[3:0]);
        endcase
    endfunction

    function automatic logic [7:0] body_byte(input logic [2:0] kind, input logic [3:0] k,
                                             input logic [7:0] c, input logic [15:0] v0,
                                             input logic [15:0] v1);
        logic [3:0] k2;
        k2 = k - 4'd6;
        case (kind)
            K_CLOSE: return CH_QUOTE;
            K_RAW:   return c;
            K_ESC2:  return (k == 4'd0) ? CH_BSL : c;
            K_U1:    return u_byte(v0, k[2:0]);
            K_U2:    return (k < 4'd6) ? u_byte(v0, k[2:0]) : u_byte(v1, k2[2:0]);
            default: return c;
        endcase
    endfunction

endpackage
`default_nettype wire

[sv/jse_if.sv]
`default_nettype none
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    modport source(output valid, output opcode, output data_byte, input ready);
    modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    modport source(output valid, output out_byte, output run_last, input ready);
    modport sink(input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

[sv/json_string_escaper_utf8.sv]
`default_nettype none
// JSON string escaper with streaming UTF-8 decoding. Feed a string one byte
// per input beat (opcode 0) and close it with an end beat (opcode 1); the
// output channel carries the escaped JSON text, quotes included, one byte
// per beat, with run_last marking the final byte caused by each input beat.
// Quote, backslash, newline, carriage return, tab, backspace and form feed
// get short escapes, other control codes become \u00xx, and with ascii_only
// set (the reset value) every code point from 0x7F up becomes \uxxxx or a
// surrogate pair. Malformed bytes pass through raw. The bytes of an
// unfinished sequence live in a small two-bank memory with a registered read;
// a new sequence always starts in the other bank, so a flush of the old
// bytes never races the write of the new lead. Input is taken at one byte
// per cycle while each byte yields at most one output byte and the output
// is not stalled; an input that yields more output bytes (twelve for a
// surrogate pair alone) holds the output sequencer, and the input waits.
// Output bytes pass the job, pending and output registers. Bytes that only
// start or extend a sequence give no output unless the opening quote is due.
module json_string_escaper_utf8 (
    input  wire logic clk,
    input  wire logic rst_n,
    jse_in_if.sink    in_ch,
    jse_out_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    import jse_pkg::*;

    job_t             job;
    logic             job_valid;
    logic             take;
    logic             ram_we;
    logic [RamAw-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [RamAw-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // Decoder: tracks the UTF-8 state and turns each accepted beat that yields output into a job.
    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .job       (job),
        .job_valid (job_valid),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // Held-byte store for unfinished sequences.
    jse_ram #(
        .Width (RamWidth),
        .Depth (RamDepth)
    ) u_held (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: walks a job beat by beat into the output register.
    jse_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .take      (take),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

[sv/jse_ram.sv]
`default_nettype none
module jse_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[sv/jse_front.sv]
`default_nettype none
module jse_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    jse_in_if.sink                   in_ch,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                take,
    output jse_pkg::job_t            job,
    output logic                     job_valid,
    output logic                     ram_we,
    output logic [jse_pkg::RamAw-1:0] ram_waddr,
    output logic [7:0]               ram_wdata
);
    import jse_pkg::*;

    logic        ascii_reg;
    logic        instr_reg, instr_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [1:0]  need_reg, need_next;
    logic [20:0] pcode_reg, pcode_next;
    logic        bank_reg, bank_next;
    logic [7:0]  lead_reg, lead_next;

    logic        acc;
    logic [7:0]  b;
    logic [7:0]  lo, hi;
    logic        cont;
    logic [20:0] pc;
    logic        do_emit;
    logic        fresh;
    logic        wr_en;
    logic [20:0] cp;
    logic [19:0] sv;

    assign acc         = in_ch.valid & take;
    assign in_ch.ready = take;
    assign b           = in_ch.data_byte;
    assign pc          = {pcode_reg[14:0], b[5:0]};
    assign sv          = 20'(cp - 21'h10000);

    // The store is written only when the beat is really taken, so an offered
    // but waiting beat never disturbs bytes that a running job still reads.
    assign ram_we      = acc & wr_en;

    // Allowed range of the next continuation byte; the second byte of a
    // sequence carries the overlong, surrogate and upper-bound checks.
    always_comb
    begin
        lo = 8'h80;
        hi = 8'hbf;
        if (hcnt_reg == 2'd1)
        begin
            case (lead_reg)
                8'he0:   lo = 8'ha0;
                8'hed:   hi = 8'h9f;
                8'hf0:   lo = 8'h90;
                8'hf4:   hi = 8'h8f;
                default: lo = 8'h80;
            endcase
        end
        cont = (b >= lo) && (b <= hi);
    end

    always_comb
    begin
        instr_next = instr_reg;
        hcnt_next  = hcnt_reg;
        need_next  = need_reg;
        pcode_next = pcode_reg;
        bank_next  = bank_reg;
        lead_next  = lead_reg;
        wr_en      = 1'b0;
        ram_waddr  = {bank_reg, hcnt_reg};
        ram_wdata  = b;
        job        = '0;
        job.open   = ~instr_reg;
        job.bank   = bank_reg;
        job.kind   = K_NONE;
        do_emit    = 1'b0;
        fresh      = 1'b0;
        cp         = '0;

        if (in_ch.opcode)
        begin
            job.nheld  = hcnt_reg;
            job.kind   = K_CLOSE;
            hcnt_next  = 2'd0;
            need_next  = 2'd0;
            pcode_next = '0;
            instr_next = 1'b0;
        end
        else
        begin
            instr_next = 1'b1;
            if ((need_reg != 2'd0) && cont)
            begin
                if (need_reg == 2'd1)
                begin
                    do_emit    = 1'b1;
                    cp         = pc;
                    hcnt_next  = 2'd0;
                    need_next  = 2'd0;
                    pcode_next = '0;
                end
                else
                begin
                    wr_en      = 1'b1;
                    hcnt_next  = hcnt_reg + 2'd1;
                    need_next  = need_reg - 2'd1;
                    pcode_next = pc;
                end
            end
            else
            begin
                job.nheld  = hcnt_reg;
                hcnt_next  = 2'd0;
                need_next  = 2'd0;
                pcode_next = '0;
                fresh      = 1'b1;
            end
        end

        if (fresh)
        begin
            if (!b[7])
            begin
                do_emit = 1'b1;
                cp      = {13'd0, b};
            end
            else if (b inside {[8'hc2:8'hdf], [8'he0:8'hef], [8'hf0:8'hf4]})
            begin
                // A new lead byte goes to the other bank so the flush of the
                // old sequence can still read its bytes.
                wr_en      = 1'b1;
                ram_waddr  = {~bank_reg, 2'd0};
                bank_next  = ~bank_reg;
                hcnt_next  = 2'd1;
                lead_next  = b;
                if (b < 8'he0)
                begin
                    need_next  = 2'd1;
                    pcode_next = {16'd0, b[4:0]};
                end
                else if (b < 8'hf0)
                begin
                    need_next  = 2'd2;
                    pcode_next = {17'd0, b[3:0]};
                end
                else
                begin
                    need_next  = 2'd3;
                    pcode_next = {18'd0, b[2:0]};
                end
            end
            else
            begin
                job.kind = K_RAW;
                job.c    = b;
            end
        end

        if (do_emit)
        begin
            if ((cp == 21'h22) || (cp == 21'h5c))
            begin
                job.kind = K_ESC2;
                job.c    = cp[7:0];
            end
            else if (cp == 21'h0a)
            begin
                job.kind = K_ESC2;
                job.c    = 8'h6e;
            end
            else if (cp == 21'h0d)
            begin
                job.kind = K_ESC2;
                job.c    = 8'h72;
            end
            else if (cp == 21'h09)
            begin
                job.kind = K_ESC2;
                job.c    = 8'h74;
            end
            else if (cp == 21'h08)
            begin
                job.kind = K_ESC2;
                job.c    = 8'h62;
            end
            else if (cp == 21'h0c)
            begin
                job.kind = K_ESC2;
                job.c    = 8'h66;
            end
            else if (cp < 21'h20)
            begin
                job.kind = K_U1;
                job.v0   = {11'd0, cp[4:0]};
            end
            else if ((cp < 21'h7f) || ((cp == 21'h7f) && !ascii_reg))
            begin
                job.kind = K_RAW;
                job.c    = cp[7:0];
            end
            else if (!ascii_reg)
            begin
                // Raw pass-through of a complete multibyte sequence.
                job.nheld = hcnt_reg;
                job.kind  = K_RAW;
                job.c     = b;
            end
            else if (cp < 21'h10000)
            begin
                job.kind = K_U1;
                job.v0   = cp[15:0];
            end
            else
            begin
                job.kind = K_U2;
                job.v0   = 16'hd800 + {6'd0, sv[19:10]};
                job.v1   = 16'hdc00 + {6'd0, sv[9:0]};
            end
        end
    end

    assign job_valid = acc && (job.open || (job.nheld != 2'd0) || (job.kind != K_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_reg <= 1'b1;
            instr_reg <= 1'b0;
            hcnt_reg  <= 2'd0;
            need_reg  <= 2'd0;
            pcode_reg <= '0;
            bank_reg  <= 1'b0;
            lead_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ascii_reg <= cfg_wdata;
            end
            if (acc)
            begin
                instr_reg <= instr_next;
                hcnt_reg  <= hcnt_next;
                need_reg  <= need_next;
                pcode_reg <= pcode_next;
                bank_reg  <= bank_next;
                lead_reg  <= lead_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_need_has_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (need_reg != 2'd0) |-> (hcnt_reg != 2'd0))
        else $error("continuation expected with no lead byte held");
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, hcnt_reg} + {1'b0, need_reg}) <= 3'd4))
        else $error("held plus expected bytes exceed four");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_ch.opcode) |=> ((hcnt_reg == 2'd0) && !instr_reg))
        else $error("end beat left a sequence or an open string behind");
`endif
endmodule
`default_nettype wire

[sv/jse_emit.sv]
`default_nettype none
module jse_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jse_pkg::job_t        job,
    input  wire logic                 job_valid,
    output logic                      take,
    output logic                      ram_re,
    output logic [jse_pkg::RamAw-1:0] ram_raddr,
    input  wire logic [7:0]           ram_rdata,
    jse_out_if.source                 out_ch
);
    import jse_pkg::*;

    logic       jvalid_reg;
    job_t       job_reg;
    logic [3:0] step_reg;
    logic       pvalid_reg;
    logic       pram_reg;
    logic [7:0] pbyte_reg;
    logic       plast_reg;
    logic       ovalid_reg;
    logic [7:0] obyte_reg;
    logic       olast_reg;

    logic [3:0] total;
    logic [3:0] j;
    logic [3:0] k;
    logic       is_open;
    logic       in_held;
    logic       last;
    logic       p_move;
    logic       issue;
    logic [7:0] step_byte;

    assign total   = {3'd0, job_reg.open} + {2'd0, job_reg.nheld} + body_len(job_reg.kind);
    assign j       = step_reg - {3'd0, job_reg.open};
    assign k       = j - {2'd0, job_reg.nheld};
    assign is_open = job_reg.open && (step_reg == 4'd0);
    assign in_held = !is_open && (j < {2'd0, job_reg.nheld});
    assign last    = (step_reg == (total - 4'd1));

    assign p_move  = pvalid_reg && (!ovalid_reg || out_ch.ready);
    assign issue   = jvalid_reg && (!pvalid_reg || p_move);
    assign take    = !jvalid_reg || (issue && last);

    assign ram_re    = issue && in_held;
    assign ram_raddr = {job_reg.bank, j[1:0]};

    assign step_byte = is_open ? CH_QUOTE
                               : body_byte(job_reg.kind, k, job_reg.c, job_reg.v0, job_reg.v1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jvalid_reg <= 1'b0;
            step_reg   <= 4'd0;
            pvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                jvalid_reg <= job_valid;
                step_reg   <= 4'd0;
            end
            else if (issue)
            begin
                step_reg <= step_reg + 4'd1;
            end

            if (issue)
            begin
                pvalid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                pvalid_reg <= 1'b0;
            end

            if (p_move)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job;
        end
        if (issue)
        begin
            pram_reg  <= in_held;
            pbyte_reg <= step_byte;
            plast_reg <= last;
        end
        if (p_move)
        begin
            obyte_reg <= pram_reg ? ram_rdata : pbyte_reg;
            olast_reg <= plast_reg;
        end
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.out_byte = obyte_reg;
    assign out_ch.run_last = olast_reg;

`ifndef SYNTHESIS
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        jvalid_reg |-> (total != 4'd0))
        else $error("active job has no beats");
    a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (pvalid_reg && pram_reg))
        else $error("store read not tracked by pending stage");
    a_job_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last && !job_valid) |=> !jvalid_reg)
        else $error("job did not retire after its last beat");
`endif
endmodule
`default_nettype wire
